FILE: rtl/ipfc_pkg.sv
// Shared types, constants and helper tables of the posture classifier.
// No dependencies.
`timescale 1ns / 1ps
package ipfc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_TABLE_LEN  = 24;
    localparam int QUARTER_TURN     = 11520;

    // accumulator widths
    localparam int CW = 44;   // CORDIC x/y, signed
    localparam int ZW = 24;   // angle, 1/65536 degree, signed

    localparam logic [2:0] POST_STILL    = 3'd0;
    localparam logic [2:0] POST_STANDING = 3'd1;
    localparam logic [2:0] POST_LYING    = 3'd2;
    localparam logic [2:0] POST_WALKING  = 3'd3;
    localparam logic [2:0] POST_FALL     = 3'd4;
    localparam logic [2:0] POST_UNDET    = 3'd5;

    localparam logic [2:0] REG_FALL_ACCEL = 3'd0;
    localparam logic [2:0] REG_FALL_ROT   = 3'd1;
    localparam logic [2:0] REG_LYING      = 3'd2;
    localparam logic [2:0] REG_WALKING    = 3'd3;
    localparam logic [2:0] REG_STILL      = 3'd4;
    localparam logic [2:0] REG_STANDING   = 3'd5;

    function automatic logic [ZW-1:0] atan_entry(input int i);
        logic [ZW-1:0] v;
        case (i)
            0: v = 24'd2949120;  1: v = 24'd1740967;  2: v = 24'd919879;
            3: v = 24'd466945;   4: v = 24'd234379;   5: v = 24'd117304;
            6: v = 24'd58666;    7: v = 24'd29335;    8: v = 24'd14668;
            9: v = 24'd7334;     10: v = 24'd3667;    11: v = 24'd1833;
            12: v = 24'd917;     13: v = 24'd458;     14: v = 24'd229;
            15: v = 24'd115;     16: v = 24'd57;      17: v = 24'd29;
            18: v = 24'd14;      19: v = 24'd7;       20: v = 24'd4;
            21: v = 24'd2;       22: v = 24'd1;       default: v = 24'd0;
        endcase
        return v;
    endfunction

    // one CORDIC lane moving down the row
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;   // numerator sign
        logic                 zero;  // numerator zero
        logic                 vert;  // denominator zero
    } cordic_lane_t;

    // one square-root lane moving down the row
    typedef struct packed {
        logic [49:0] rem;
        logic [25:0] root;
    } sqrt_lane_t;

    // side data carried beside the arithmetic
    typedef struct packed {
        logic [16:0] rot;
    } side_t;

endpackage

FILE: rtl/ipfc_if.sv
// Valid/ready channel interfaces for samples and results.
// No dependencies.
`timescale 1ns / 1ps
interface ipfc_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  output ready);
endinterface

interface ipfc_out_if;
    logic valid;
    logic ready;
    logic [15:0] accel_magnitude;
    logic [16:0] rotation_sum;
    logic signed [14:0] pitch_angle;
    logic signed [14:0] roll_angle;
    logic [2:0] posture;
    logic fall_flag;
    modport source (output valid, accel_magnitude, rotation_sum, pitch_angle,
                    roll_angle, posture, fall_flag, input ready);
    modport sink (input valid, accel_magnitude, rotation_sum, pitch_angle,
                  roll_angle, posture, fall_flag, output ready);
endinterface

FILE: rtl/ipfc_sqrt_cell.sv
// One restoring square-root cell: takes two radicand bits, gives one root bit.
// Depends on ipfc_pkg.
`timescale 1ns / 1ps
module ipfc_sqrt_cell
    import ipfc_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [1:0] pair,
    input  sqrt_lane_t lane_in,
    output sqrt_lane_t lane_out
);
    sqrt_lane_t lane_reg;
    sqrt_lane_t lane_next;
    logic [49:0] trial;
    logic [49:0] shifted;

    always_comb
    begin
        shifted = {lane_in.rem[47:0], pair};
        trial   = {22'd0, lane_in.root, 2'b01};
        if (shifted >= trial)
        begin
            lane_next.rem  = shifted - trial;
            lane_next.root = {lane_in.root[24:0], 1'b1};
        end
        else
        begin
            lane_next.rem  = shifted;
            lane_next.root = {lane_in.root[24:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;
endmodule

FILE: rtl/ipfc_cordic_cell.sv
// One vectoring CORDIC micro-rotation cell with a fixed shift.
// Depends on ipfc_pkg.
`timescale 1ns / 1ps
module ipfc_cordic_cell
    import ipfc_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic         clk,
    input  logic         en,
    input  cordic_lane_t lane_in,
    output cordic_lane_t lane_out
);
    cordic_lane_t lane_reg;
    cordic_lane_t lane_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [ZW-1:0] step;

    always_comb
    begin
        xs = lane_in.x >>> SHIFT;
        ys = lane_in.y >>> SHIFT;
        step = atan_entry(SHIFT);
        lane_next = lane_in;
        if (!lane_in.y[CW-1])
        begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + $signed(step);
        end
        else
        begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - $signed(step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;
endmodule

FILE: rtl/imu_posture_fall_classifier_core.sv
// Top level of the posture and fall classifier: register file, cell rows,
// classification and output stage. Depends on ipfc_pkg, ipfc_if and the cells.
`timescale 1ns / 1ps
// The block takes one IMU sample per cycle while the output is not stalled and
// gives one result per sample, in order, through 1 input stage, 25 square-root
// cells (one root bit per cell; 24 for the tilt denominator roots plus one), a
// prepare stage, min(CORDIC_STEPS, ANGLE_TABLE_LEN) rotation cells, two
// rounding stages and one classification stage ending in the output register.
// The whole pipe advances as one whenever the output register is empty or
// being taken, so a stalled sink holds the row and ready falls only then.
// Thresholds are written through the APB port (byte address 4*i) by the user
// only while the block is idle (unchecked); reads return the register values.
module imu_posture_fall_classifier_core
    import ipfc_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ipfc_in_if.sink     sample,
    ipfc_out_if.source  result
);
    localparam int NSTEP = (CORDIC_STEPS < ANGLE_TABLE_LEN) ? CORDIC_STEPS
                                                             : ANGLE_TABLE_LEN;
    localparam int NSQ  = 25;              // root bits of a 50-bit radicand
    localparam int LAT  = NSQ + NSTEP + 4; // valid shift line length

    // ---------------- registers ----------------
    logic [15:0] fall_accel_reg;
    logic [16:0] fall_rot_reg;
    logic [13:0] lying_reg;
    logic [16:0] walking_reg;
    logic [16:0] still_reg;
    logic [13:0] standing_reg;
    logic        wr;
    logic [2:0]  widx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fall_accel_reg <= 16'd4506;
            fall_rot_reg   <= 17'd2880;
            lying_reg      <= 14'd7040;
            walking_reg    <= 17'd1120;
            still_reg      <= 17'd192;
            standing_reg   <= 14'd3840;
        end
        else if (wr)
        begin
            case (widx)
                REG_FALL_ACCEL: fall_accel_reg <= pwdata[15:0];
                REG_FALL_ROT:   fall_rot_reg   <= pwdata[16:0];
                REG_LYING:      lying_reg      <= pwdata[13:0];
                REG_WALKING:    walking_reg    <= pwdata[16:0];
                REG_STILL:      still_reg      <= pwdata[16:0];
                REG_STANDING:   standing_reg   <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_FALL_ACCEL: prdata = {16'd0, fall_accel_reg};
            REG_FALL_ROT:   prdata = {15'd0, fall_rot_reg};
            REG_LYING:      prdata = {18'd0, lying_reg};
            REG_WALKING:    prdata = {15'd0, walking_reg};
            REG_STILL:      prdata = {15'd0, still_reg};
            REG_STANDING:   prdata = {18'd0, standing_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    logic           out_valid_reg;
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], sample.valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end
    assign result.valid = out_valid_reg;

    // ---------------- input stage: squares and rotation sum ----------------
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0] sx_reg, sy_reg, sz_reg;
    logic [16:0] rot_reg;
    logic [16:0] abs_rx, abs_ry, abs_rz;

    assign abs_rx = sample.rate_x[15] ? 17'd0 - {1'b1, sample.rate_x} : {1'b0, sample.rate_x};
    assign abs_ry = sample.rate_y[15] ? 17'd0 - {1'b1, sample.rate_y} : {1'b0, sample.rate_y};
    assign abs_rz = sample.rate_z[15] ? 17'd0 - {1'b1, sample.rate_z} : {1'b0, sample.rate_z};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg  <= sample.accel_x;
            ay_reg  <= sample.accel_y;
            az_reg  <= sample.accel_z;
            sx_reg  <= 32'($signed(sample.accel_x) * $signed(sample.accel_x));
            sy_reg  <= 32'($signed(sample.accel_y) * $signed(sample.accel_y));
            sz_reg  <= 32'($signed(sample.accel_z) * $signed(sample.accel_z));
            rot_reg <= abs_rx + abs_ry + abs_rz;
        end
    end

    // radicands: magnitude, pitch denominator (y,z) * 2^16, roll (x,z) * 2^16
    logic [49:0] rad_m, rad_p, rad_r;
    assign rad_m = 50'(sx_reg) + 50'(sy_reg) + 50'(sz_reg);
    assign rad_p = (50'(sy_reg) + 50'(sz_reg)) << 16;
    assign rad_r = (50'(sx_reg) + 50'(sz_reg)) << 16;

    // radicands travel beside the root row, one pair consumed per cell
    logic [49:0] rm_line [NSQ+1];
    logic [49:0] rp_line [NSQ+1];
    logic [49:0] rr_line [NSQ+1];
    sqrt_lane_t  lm [NSQ+1];
    sqrt_lane_t  lp [NSQ+1];
    sqrt_lane_t  lr [NSQ+1];
    logic signed [15:0] axl [NSQ+1];
    logic signed [15:0] ayl [NSQ+1];
    logic [16:0] rotl [NSQ+1];

    assign rm_line[0] = rad_m;
    assign rp_line[0] = rad_p;
    assign rr_line[0] = rad_r;
    assign lm[0] = '0;
    assign lp[0] = '0;
    assign lr[0] = '0;
    assign axl[0] = ax_reg;
    assign ayl[0] = ay_reg;
    assign rotl[0] = rot_reg;

    for (genvar k = 0; k < NSQ; k++) begin : g_sq
        ipfc_sqrt_cell u_m (.clk(clk), .en(adv), .pair(rm_line[k][49:48]),
                            .lane_in(lm[k]), .lane_out(lm[k+1]));
        ipfc_sqrt_cell u_p (.clk(clk), .en(adv), .pair(rp_line[k][49:48]),
                            .lane_in(lp[k]), .lane_out(lp[k+1]));
        ipfc_sqrt_cell u_r (.clk(clk), .en(adv), .pair(rr_line[k][49:48]),
                            .lane_in(lr[k]), .lane_out(lr[k+1]));
        logic [49:0] rm_reg, rp_reg, rr_reg;
        logic signed [15:0] ax_d, ay_d;
        logic [16:0] rot_d;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rm_reg <= {rm_line[k][47:0], 2'b00};
                rp_reg <= {rp_line[k][47:0], 2'b00};
                rr_reg <= {rr_line[k][47:0], 2'b00};
                ax_d   <= axl[k];
                ay_d   <= ayl[k];
                rot_d  <= rotl[k];
            end
        end
        assign rm_line[k+1] = rm_reg;
        assign rp_line[k+1] = rp_reg;
        assign rr_line[k+1] = rr_reg;
        assign axl[k+1] = ax_d;
        assign ayl[k+1] = ay_d;
        assign rotl[k+1] = rot_d;
    end

    // ---------------- prepare CORDIC lanes ----------------
    logic [15:0] mag_sat;
    assign mag_sat = (lm[NSQ].root > 26'd65535) ? 16'hFFFF : lm[NSQ].root[15:0];

    function automatic cordic_lane_t prep(input logic signed [15:0] num,
                                          input logic [25:0] den);
        cordic_lane_t l;
        logic [15:0] mabs;
        mabs   = num[15] ? 16'(-num) : 16'(num);
        l.x    = CW'({den, 16'd0});
        l.y    = CW'({mabs, 24'd0});
        l.z    = '0;
        l.neg  = num[15];
        l.zero = (num == 16'sd0);
        l.vert = (den == 26'd0);
        return l;
    endfunction

    cordic_lane_t cp [NSTEP+1];
    cordic_lane_t cr [NSTEP+1];
    logic [15:0]  magl [NSTEP+1];
    logic [16:0]  rotc [NSTEP+1];
    cordic_lane_t cp0_reg, cr0_reg;
    logic [15:0]  mag0_reg;
    logic [16:0]  rot0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp0_reg  <= prep(axl[NSQ], lp[NSQ].root);
            cr0_reg  <= prep(ayl[NSQ], lr[NSQ].root);
            mag0_reg <= mag_sat;
            rot0_reg <= rotl[NSQ];
        end
    end
    assign cp[0] = cp0_reg;
    assign cr[0] = cr0_reg;
    assign magl[0] = mag0_reg;
    assign rotc[0] = rot0_reg;

    for (genvar s = 0; s < NSTEP; s++) begin : g_cor
        ipfc_cordic_cell #(.SHIFT(s)) u_p (.clk(clk), .en(adv),
                                           .lane_in(cp[s]), .lane_out(cp[s+1]));
        ipfc_cordic_cell #(.SHIFT(s)) u_r (.clk(clk), .en(adv),
                                           .lane_in(cr[s]), .lane_out(cr[s+1]));
        logic [15:0] mag_d;
        logic [16:0] rot_d;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mag_d <= magl[s];
                rot_d <= rotc[s];
            end
        end
        assign magl[s+1] = mag_d;
        assign rotc[s+1] = rot_d;
    end

    // ---------------- rounding ----------------
    function automatic logic signed [14:0] finish(input cordic_lane_t l);
        logic signed [ZW-1:0] r;
        logic signed [ZW-1:0] a;
        logic [13:0] m;
        r = (l.z + 24'sd256) >>> 9;
        a = r;
        if (r < 0)
            m = 14'd0;
        else if (a > ZW'(QUARTER_TURN))
            m = 14'(QUARTER_TURN);
        else
            m = r[13:0];
        if (l.zero)
            m = 14'd0;
        else if (l.vert)
            m = 14'(QUARTER_TURN);
        return l.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    logic signed [14:0] pitch_reg, roll_reg;
    logic [15:0] mag1_reg;
    logic [16:0] rot1_reg;
    // extra alignment register so the row length matches LAT
    logic signed [14:0] pitch_q, roll_q;
    logic [15:0] mag_q;
    logic [16:0] rot_q;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_q   <= finish(cp[NSTEP]);
            roll_q    <= finish(cr[NSTEP]);
            mag_q     <= magl[NSTEP];
            rot_q     <= rotc[NSTEP];
            pitch_reg <= pitch_q;
            roll_reg  <= roll_q;
            mag1_reg  <= mag_q;
            rot1_reg  <= rot_q;
        end
    end

    // ---------------- classification and output register ----------------
    logic [13:0] abs_pitch;
    logic [2:0]  post;
    assign abs_pitch = pitch_reg[14] ? 14'(-pitch_reg) : pitch_reg[13:0];

    always_comb
    begin
        if (mag1_reg > fall_accel_reg && rot1_reg > fall_rot_reg)
            post = POST_FALL;
        else if (abs_pitch > lying_reg)
            post = POST_LYING;
        else if (rot1_reg > walking_reg)
            post = POST_WALKING;
        else if (rot1_reg < still_reg)
            post = POST_STILL;
        else if (abs_pitch < standing_reg)
            post = POST_STANDING;
        else
            post = POST_UNDET;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result.accel_magnitude <= mag1_reg;
            result.rotation_sum    <= rot1_reg;
            result.pitch_angle     <= pitch_reg;
            result.roll_angle      <= roll_reg;
            result.posture         <= post;
            result.fall_flag       <= (post == POST_FALL);
        end
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.posture))
        else $error("result changed under stall");
    a_fall_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.fall_flag == (result.posture == POST_FALL)))
        else $error("fall flag and posture disagree");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> sample.ready)
        else $error("input stalled with empty output");
`endif
endmodule

FILE: verif/imu_posture_fall_classifier_core_tb.sv
// Self-checking testbench for the posture and fall classifier core.
// Holds its own fixed-point predictor, APB register writer and request checker.
// Depends on ipfc_pkg, ipfc_if and the core RTL.
`timescale 1ns / 1ps
module imu_posture_fall_classifier_core_tb;
    import ipfc_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int LATENCY     = STEPS + 30;      // pipe depth of the core
    localparam int REG_COUNT   = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 960;

    // two addresses past the register list, writes there must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    localparam longint ATAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [15:0] ax, ay, az, rx, ry, rz;
    } imu_sample_t;

    typedef struct packed {
        logic [15:0]        magnitude;
        logic [16:0]        rotation;
        logic signed [14:0] pitch;
        logic signed [14:0] roll;
        logic [2:0]         posture;
        logic               fall;
    } posture_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ipfc_in_if  sample_ch();
    ipfc_out_if result_ch();

    imu_posture_fall_classifier_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch.sink),
        .result  (result_ch.source)
    );

    always #1 clk = ~clk;

    // thresholds as the predictor sees them, indexed by register number
    logic [31:0]     thresholds [REG_COUNT];
    posture_result_t pending_results [$];
    int  errors = 0;
    int  cycles = 0;
    int  requests_sent = 0;
    int  results_seen = 0;
    int  falls_seen = 0;
    bit  src_idle_en = 1'b0;
    bit  snk_idle_en = 1'b0;
    int  stall_left = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // atan2(num, sqrt(b^2 + c^2)) in 1/128 degree, vectoring CORDIC
    function automatic longint tilt_angle(input longint num, input longint b,
                                          input longint c);
        longint unsigned den, mag;
        longint x, y, z, xs, ys, ang;
        den = int_sqrt(longint'(b * b + c * c) << 16);
        mag = longint'(num < 0 ? -num : num) << 8;
        z = 0;
        if (mag == 0)
            return 0;
        if (den == 0)
            return num < 0 ? -QUARTER_TURN : QUARTER_TURN;
        x = longint'(den << 16);
        y = longint'(mag << 16);
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += ATAN_DEG[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ATAN_DEG[i];
            end
        end
        ang = (z + 256) >>> 9;
        if (ang < 0)
            ang = 0;
        if (ang > QUARTER_TURN)
            ang = QUARTER_TURN;
        return num < 0 ? -ang : ang;
    endfunction

    function automatic posture_result_t classify_sample(input imu_sample_t s);
        posture_result_t r;
        longint ax, ay, az, rot, p, q, abs_p;
        longint unsigned mag;
        ax = s.ax;
        ay = s.ay;
        az = s.az;
        mag = int_sqrt(longint'(ax * ax + ay * ay + az * az));
        if (mag > 65535)
            mag = 65535;
        rot = (s.rx < 0 ? -longint'(s.rx) : longint'(s.rx))
            + (s.ry < 0 ? -longint'(s.ry) : longint'(s.ry))
            + (s.rz < 0 ? -longint'(s.rz) : longint'(s.rz));
        p = tilt_angle(ax, ay, az);
        q = tilt_angle(ay, ax, az);
        abs_p = p < 0 ? -p : p;
        r.magnitude = mag[15:0];
        r.rotation  = rot[16:0];
        r.pitch     = p[14:0];
        r.roll      = q[14:0];
        r.fall      = 1'b0;
        if (mag > thresholds[REG_FALL_ACCEL] && rot > thresholds[REG_FALL_ROT]) begin
            r.posture = POST_FALL;
            r.fall = 1'b1;
        end else if (abs_p > thresholds[REG_LYING])
            r.posture = POST_LYING;
        else if (rot > thresholds[REG_WALKING])
            r.posture = POST_WALKING;
        else if (rot < thresholds[REG_STILL])
            r.posture = POST_STILL;
        else if (abs_p < thresholds[REG_STANDING])
            r.posture = POST_STANDING;
        else
            r.posture = POST_UNDET;
        return r;
    endfunction

    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        case (idx)
            REG_FALL_ACCEL:             return 32'h0000_FFFF;
            REG_LYING, REG_STANDING:    return 32'h0000_3FFF;
            default:                    return 32'h0001_FFFF;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Timeout and sink-side back-pressure
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** imu_posture_fall_classifier_core: FAILED **");
            $finish;
        end
    end

    initial result_ch.ready = 1'b0;

    // random stall bursts on the sink side, started only while enabled
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_ch.ready = 1'b0;
        end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            result_ch.ready = 1'b0;
        end else begin
            result_ch.ready = rst_n;
        end
    end

    // ---------------------------------------------------------------
    // Result checker: each accepted request against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        posture_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no prediction waiting");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.fall)
                    falls_seen++;
                if (result_ch.accel_magnitude !== want.magnitude) begin
                    $error("accel_magnitude: expected %0d, got %0d",
                           want.magnitude, result_ch.accel_magnitude);
                    errors++;
                end
                if (result_ch.rotation_sum !== want.rotation) begin
                    $error("rotation_sum: expected %0d, got %0d",
                           want.rotation, result_ch.rotation_sum);
                    errors++;
                end
                if (result_ch.pitch_angle !== want.pitch) begin
                    $error("pitch_angle: expected %0d, got %0d",
                           want.pitch, result_ch.pitch_angle);
                    errors++;
                end
                if (result_ch.roll_angle !== want.roll) begin
                    $error("roll_angle: expected %0d, got %0d",
                           want.roll, result_ch.roll_angle);
                    errors++;
                end
                if (result_ch.posture !== want.posture) begin
                    $error("posture: expected %0d, got %0d",
                           want.posture, result_ch.posture);
                    errors++;
                end
                if (result_ch.fall_flag !== want.fall) begin
                    $error("fall_flag: expected %0d, got %0d",
                           want.fall, result_ch.fall_flag);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers (all called on the falling edge)
    // ---------------------------------------------------------------
    task automatic send_sample(input imu_sample_t s);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            sample_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        sample_ch.valid   = 1'b1;
        sample_ch.accel_x = s.ax;
        sample_ch.accel_y = s.ay;
        sample_ch.accel_z = s.az;
        sample_ch.rate_x  = s.rx;
        sample_ch.rate_y  = s.ry;
        sample_ch.rate_z  = s.rz;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_results.push_back(classify_sample(s));
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_axes(input int ax, input int ay, input int az,
                             input int rx, input int ry, input int rz);
        imu_sample_t s;
        s = {16'(ax), 16'(ay), 16'(az), 16'(rx), 16'(ry), 16'(rz)};
        send_sample(s);
    endtask

    // waits for the pipe to empty; valid drops so nothing more is taken
    task automatic drain;
        sample_ch.valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx < REG_COUNT)
            thresholds[idx] = value & reg_mask(idx);
    endtask

    task automatic apb_check(input logic [2:0] idx);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== thresholds[idx]) begin
            $error("register %0d: expected %0d, got %0d", idx, thresholds[idx], prdata);
            errors++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_thresholds(input logic [31:0] v0, input logic [31:0] v1,
                                      input logic [31:0] v2, input logic [31:0] v3,
                                      input logic [31:0] v4, input logic [31:0] v5);
        apb_write(REG_FALL_ACCEL, v0);
        apb_write(REG_FALL_ROT, v1);
        apb_write(REG_LYING, v2);
        apb_write(REG_WALKING, v3);
        apb_write(REG_STILL, v4);
        apb_write(REG_STANDING, v5);
        for (int i = 0; i < REG_COUNT; i++)
            apb_check(3'(i));
    endtask

    // mostly axes within +-3000 (rates half), sometimes +-20000 or fully random
    task automatic send_random_sample;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            send_axes($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            span = (kind >= 8) ? 20000 : 3000;
            send_axes($urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 2 * (span / 2)) - span / 2,
                      $urandom_range(0, 2 * (span / 2)) - span / 2,
                      $urandom_range(0, 2 * (span / 2)) - span / 2);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_reset_values;
        thresholds[REG_FALL_ACCEL] = 4506;
        thresholds[REG_FALL_ROT]   = 2880;
        thresholds[REG_LYING]      = 7040;
        thresholds[REG_WALKING]    = 1120;
        thresholds[REG_STILL]      = 192;
        thresholds[REG_STANDING]   = 3840;
        for (int i = 0; i < REG_COUNT; i++)
            apb_check(3'(i));
    endtask

    task automatic test_directed_samples;
        send_axes(0, 0, 0, 0, 0, 0);                         // all zero
        send_axes(32767, 0, 0, 0, 0, 0);                     // pitch with no denominator
        send_axes(-32768, 0, 0, 100, 0, 0);
        send_axes(0, -32768, 0, 0, 0, 0);                    // roll with no denominator
        send_axes(0, 1, 0, 0, 0, 0);
        send_axes(1, 0, 1, 0, 0, 0);
        send_axes(-32768, -32768, -32768, -32768, -32768, -32768);
        send_axes(32767, 32767, 32767, 32767, 32767, 32767);
        send_axes(0, 0, 2048, 0, 0, 0);                      // upright, still
        send_axes(0, 0, 2048, 200, 0, 0);                    // standing
        send_axes(500, 0, 2048, 600, 600, 0);                // walking
        send_axes(2048, 0, 100, 50, 0, 0);                   // lying
        send_axes(1448, 0, 1448, 300, 0, 0);                 // undetermined band
        send_axes(6000, 6000, 0, 2000, 2000, 0);             // fall
        send_axes(4506, 0, 0, 2881, 0, 0);                   // magnitude on its fall limit, rotation just past
        send_axes(4506, 0, 0, 2880, 0, 0);                   // exactly on the limit
        send_axes(0, 0, 2048, 1120, 0, 0);
        send_axes(0, 0, 2048, 192, 0, 0);
        send_axes(0, 0, 2048, 191, 0, 0);
        send_axes(-2048, 0, 0, 0, 0, -50);
        send_axes(0, 2048, -2048, 0, -300, 0);
        drain();
    endtask

    task automatic test_threshold_extremes;
        program_thresholds(0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 40; i++)
            send_random_sample();
        send_axes(0, 0, 0, 0, 0, 0);
        drain();
        program_thresholds('1, '1, '1, '1, '1, '1);          // masked to width
        for (int i = 0; i < 40; i++)
            send_random_sample();
        drain();
        program_thresholds(65535, 131071, 11520, 131071, 131071, 11520);
        for (int i = 0; i < 40; i++)
            send_random_sample();
        drain();
    endtask

    task automatic test_spare_addresses;
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        for (int i = 0; i < REG_COUNT; i++)
            apb_check(3'(i));
    endtask

    task automatic test_random_traffic;
        for (int phase = 0; phase < 6; phase++) begin
            src_idle_en = (phase % 3) != 2;
            snk_idle_en = (phase % 3) != 1;
            if (phase == 5) begin
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end
            if (phase == 0)
                program_thresholds(4506, 2880, 7040, 1120, 192, 3840);
            else
                program_thresholds($urandom_range(1500, 9000), $urandom_range(100, 4000),
                                   $urandom_range(0, 11520), $urandom_range(100, 3000),
                                   $urandom_range(0, 800), $urandom_range(0, 11520));
            for (int i = 0; i < N_RANDOM / 6; i++)
                send_random_sample();
            drain();
        end
    endtask

    initial begin
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.rate_x  = '0;
        sample_ch.rate_y  = '0;
        sample_ch.rate_z  = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        test_directed_samples();
        test_threshold_extremes();
        test_spare_addresses();
        test_random_traffic();

        $display("Sent %0d samples, checked %0d results (%0d falls) over %0d cycles,",
                 requests_sent, results_seen, falls_seen, cycles);
        $display("covering reset, extreme and random thresholds with stalls on both sides.");
        if (errors == 0)
            $display("** imu_posture_fall_classifier_core: PASSED **");
        else
            $display("** imu_posture_fall_classifier_core: FAILED **");
        $finish;
    end

endmodule
